// ----- hw/rtl/integral_image_builder_assert.svh -----
// Assertion macros used by the integral image builder checker
`ifndef INTEGRAL_IMAGE_BUILDER_ASSERT_SVH
`define INTEGRAL_IMAGE_BUILDER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted
`define IIB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted
`define IIB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset
`define IIB_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/iib_pkg.sv -----
// Types and constants of the integral image builder
package iib_pkg;

  localparam int SUM_W  = 28;
  localparam int CFG_W  = 11;

  typedef logic [CFG_W-1:0] cfg_data_t;
  typedef logic [0:0]       cfg_idx_t;
  typedef logic [SUM_W-1:0] sum_t;

  localparam cfg_idx_t  REG_ROW_LENGTH = 1'b0;
  localparam cfg_idx_t  REG_ROW_COUNT  = 1'b1;
  localparam cfg_data_t CFG_RESET      = 11'd1024;

  // per-pixel classification from the front end
  typedef struct packed {
    logic first_row;
    logic row_end;
    logic plane_end;
  } flags_t;

  typedef struct packed {
    sum_t area_sum;
    logic row_end;
    logic plane_end;
  } res_t;

endpackage

// ----- hw/rtl/iib_fifo.sv -----
// Small register FIFO used between pipeline parts
module iib_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/iib_front.sv -----
// Front end: config registers, column/row tracking, pixel classification
module iib_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int CW         = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  iib_pkg::cfg_idx_t     cfg_index,
  input  iib_pkg::cfg_data_t    cfg_data,
  input  logic                  in_push,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  output logic                  in_full,
  output logic                  q_push,
  output logic [PIXEL_BITS-1:0] q_pixel,
  output logic [CW-1:0]         q_col,
  output iib_pkg::flags_t       q_flags,
  input  logic                  q_full
);
  import iib_pkg::*;

  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LWW  = $clog2(MAX_WIDTH + 1);
  localparam int LWH  = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = (LWW > CFG_W) ? LWW : CFG_W;
  localparam int CMPH = (LWH > CFG_W) ? LWH : CFG_W;

  cfg_data_t     row_length_r, row_count_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic [CMPW-1:0] len_ext, len_eff, last_col;
  logic [CMPH-1:0] cnt_ext, cnt_eff, last_row;
  logic            accept, row_end, plane_end;

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    len_ext = CMPW'(row_length_r);
    if (len_ext == '0) begin
      len_eff = CMPW'(1);
    end else if (len_ext > CMPW'(MAX_WIDTH)) begin
      len_eff = CMPW'(MAX_WIDTH);
    end else begin
      len_eff = len_ext;
    end
    cnt_ext = CMPH'(row_count_r);
    if (cnt_ext == '0) begin
      cnt_eff = CMPH'(1);
    end else if (cnt_ext > CMPH'(MAX_HEIGHT)) begin
      cnt_eff = CMPH'(MAX_HEIGHT);
    end else begin
      cnt_eff = cnt_ext;
    end
    last_col = len_eff - 1'b1;
    last_row = cnt_eff - 1'b1;
  end

  assign row_end   = (CMPW'(col_r) >= last_col);
  assign plane_end = row_end & (CMPH'(row_r) >= last_row);
  assign accept    = in_push & ~q_full;

  assign in_full             = q_full;
  assign q_push              = in_push;
  assign q_pixel             = in_pixel;
  assign q_col               = col_r;
  assign q_flags.first_row   = (row_r == '0);
  assign q_flags.row_end     = row_end;
  assign q_flags.plane_end   = plane_end;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = plane_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= CFG_RESET;
      row_count_r  <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length_r <= cfg_data;
        REG_ROW_COUNT:  row_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/iib_back.sv -----
// Back end: line buffer read, row and area accumulation, line buffer write
module iib_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int CW         = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [PIXEL_BITS-1:0] q_pixel,
  input  logic [CW-1:0]         q_col,
  input  iib_pkg::flags_t       q_flags,
  output logic                  r_push,
  output iib_pkg::res_t         r_data,
  input  logic                  r_full
);
  import iib_pkg::*;

  sum_t                  line_mem [MAX_WIDTH];

  logic                  rd_valid_r, rd_valid_nxt;
  logic [PIXEL_BITS-1:0] rd_pixel_r;
  logic [CW-1:0]         rd_col_r;
  flags_t                rd_flags_r;
  sum_t                  rd_data_r;
  logic                  byp_r;
  sum_t                  byp_data_r;
  sum_t                  run_r, run_nxt;

  logic                  fire;
  sum_t                  row_sum, above, area;

  assign fire  = rd_valid_r & ~r_full;
  assign q_pop = ~q_empty & (~rd_valid_r | fire);

  assign row_sum = run_r + SUM_W'(rd_pixel_r);
  // the line buffer read misses a write to the same column on the same edge
  assign above   = rd_flags_r.first_row ? '0 : (byp_r ? byp_data_r : rd_data_r);
  assign area    = row_sum + above;

  assign r_push           = fire;
  assign r_data.area_sum  = area;
  assign r_data.row_end   = rd_flags_r.row_end;
  assign r_data.plane_end = rd_flags_r.plane_end;

  always_comb begin
    rd_valid_nxt = rd_valid_r;
    run_nxt      = run_r;
    if (q_pop) begin
      rd_valid_nxt = 1'b1;
    end else if (fire) begin
      rd_valid_nxt = 1'b0;
    end
    if (fire) begin
      run_nxt = rd_flags_r.row_end ? '0 : row_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      run_r      <= '0;
    end else begin
      rd_valid_r <= rd_valid_nxt;
      run_r      <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_pixel_r <= q_pixel;
      rd_col_r   <= q_col;
      rd_flags_r <= q_flags;
      rd_data_r  <= line_mem[q_col];
      byp_r      <= fire && (rd_col_r == q_col);
      byp_data_r <= area;
    end
    if (fire) begin
      line_mem[rd_col_r] <= area;
    end
  end

endmodule

// ----- hw/rtl/integral_image_builder.sv -----
// Integral image builder top level
//
//   port group | direction | handshake          | payload
//   in_        | in        | in_push / in_full  | in_pixel
//   out_       | out       | out_pop / out_empty| out_area_sum, out_row_end, out_plane_end
//   cfg_       | in        | cfg_we             | cfg_index, cfg_data
//
// One pixel per clock sustained unless the output stalls.
// The line buffer is one write and one read port; a same-column hit is forwarded.
// Reset (rst_n low, synchronous) empties both queues and clears the counters and row sum.
// The line buffer has no reset: the first row of each plane ignores what it reads.
// A stalled output backs up through the output queue, the back end and the middle queue.
module integral_image_builder #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  iib_pkg::cfg_idx_t     cfg_index,
  input  iib_pkg::cfg_data_t    cfg_data,
  input  logic                  in_push,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output iib_pkg::sum_t         out_area_sum,
  output logic                  out_row_end,
  output logic                  out_plane_end
);
  import iib_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int FW = $bits(flags_t);
  localparam int QW = PIXEL_BITS + CW + FW;
  localparam int OW = $bits(res_t);

  logic                  fq_push, fq_full, fq_pop, fq_empty;
  logic [PIXEL_BITS-1:0] f_pixel, b_pixel;
  logic [CW-1:0]         f_col, b_col;
  flags_t                f_flags, b_flags;
  logic [QW-1:0]         fq_rdata;

  logic                  oq_push, oq_full;
  res_t                  oq_wdata, oq_rdata;

  iib_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS),
    .CW        (CW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_pixel (in_pixel),
    .in_full  (in_full),
    .q_push   (fq_push),
    .q_pixel  (f_pixel),
    .q_col    (f_col),
    .q_flags  (f_flags),
    .q_full   (fq_full)
  );

  iib_fifo #(
    .W    (QW),
    .DEPTH(2)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fq_push),
    .wdata({f_pixel, f_col, f_flags}),
    .full (fq_full),
    .pop  (fq_pop),
    .rdata(fq_rdata),
    .empty(fq_empty)
  );

  assign {b_pixel, b_col, b_flags} = fq_rdata;

  iib_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS),
    .CW        (CW)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(fq_empty),
    .q_pop  (fq_pop),
    .q_pixel(b_pixel),
    .q_col  (b_col),
    .q_flags(b_flags),
    .r_push (oq_push),
    .r_data (oq_wdata),
    .r_full (oq_full)
  );

  iib_fifo #(
    .W    (OW),
    .DEPTH(2)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (oq_push),
    .wdata(oq_wdata),
    .full (oq_full),
    .pop  (out_pop),
    .rdata(oq_rdata),
    .empty(out_empty)
  );

  assign out_area_sum  = oq_rdata.area_sum;
  assign out_row_end   = oq_rdata.row_end;
  assign out_plane_end = oq_rdata.plane_end;

endmodule

// ----- hw/rtl/iib_checker.sv -----
// Port-level checker for the integral image builder, with its bind
`include "integral_image_builder_assert.svh"

module iib_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_full,
  input logic          out_empty,
  input logic          out_pop,
  input iib_pkg::sum_t out_area_sum,
  input logic          out_row_end,
  input logic          out_plane_end
);
  import iib_pkg::*;

  logic [SUM_W+1:0] out_word;

  assign out_word = {out_area_sum, out_row_end, out_plane_end};

  // a plane always closes on a row boundary
  `IIB_ASSERT_SAME(a_plane_on_row, !out_empty && out_plane_end, out_row_end, "plane_end without row_end")

  // both queues come out of reset empty
  `IIB_ASSERT_ALWAYS(a_reset_empty, !rst_n, out_empty && !in_full, "queues not empty after reset")

  // a waiting result holds until its transfer
  `IIB_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_word), "result changed while stalled")

endmodule

bind integral_image_builder iib_checker u_iib_checker (.*);

// ----- sim/integral_image_builder_tb.sv -----
// Self-checking testbench for the integral image builder: random planes, stalls, register changes
module integral_image_builder_tb;
  import iib_pkg::*;

  localparam int LINE_MAX    = 1024;
  localparam int ROWS_MAX    = 1024;
  localparam int PIXEL_TOTAL = 1100;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = REG_ROW_LENGTH;
  cfg_data_t cfg_data = '0;
  logic      in_push = 1'b0;
  logic [7:0] in_pixel = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop = 1'b0;
  sum_t      out_area_sum;
  logic      out_row_end;
  logic      out_plane_end;

  integral_image_builder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_pixel      (in_pixel),
    .in_full       (in_full),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_area_sum  (out_area_sum),
    .out_row_end   (out_row_end),
    .out_plane_end (out_plane_end)
  );

  always #1 clk = ~clk;

  // shadow of the block: registers, line buffer, row sum and position
  cfg_data_t row_length_reg = CFG_RESET;
  cfg_data_t row_count_reg = CFG_RESET;
  sum_t      line_sums [LINE_MAX];
  bit        col_written [LINE_MAX];
  sum_t      row_sum = '0;
  int        col_pos = 0;
  int        row_pos = 0;

  logic [7:0] pending_pixels [$];
  res_t       expected_sums [$];

  int pixels_queued = 0;
  int pixels_in = 0;
  int results_out = 0;
  int rows_out = 0;
  int planes_out = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // idle control: calm, the odds and the hold request are set by the stimulus process
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int in_gap_odds = 0;
  int out_stall_odds = 0;
  int in_gap = 0;
  int out_stall = 0;
  int hold_left = 0;

  function automatic int eff_len(cfg_data_t v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic res_t predict_area(logic [7:0] pix);
    int   len;
    int   rows;
    sum_t above;
    res_t r;
    len = eff_len(row_length_reg, LINE_MAX);
    rows = eff_len(row_count_reg, ROWS_MAX);
    row_sum = row_sum + sum_t'(pix);
    above = (row_pos != 0) ? line_sums[col_pos] : '0;
    r.area_sum = row_sum + above;
    line_sums[col_pos] = r.area_sum;
    col_written[col_pos] = 1'b1;
    r.row_end = (col_pos >= len - 1);
    r.plane_end = 1'b0;
    if (r.row_end) begin
      r.plane_end = (row_pos >= rows - 1);
      col_pos = 0;
      row_sum = '0;
      row_pos = r.plane_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  // pixels left until the current plane closes; valid only while idle
  function automatic int pixels_to_plane_end();
    int len;
    int rows;
    int n;
    len = eff_len(row_length_reg, LINE_MAX);
    rows = eff_len(row_count_reg, ROWS_MAX);
    n = (col_pos >= len - 1) ? 1 : len - col_pos;
    if (row_pos < rows - 1) n += (rows - 1 - row_pos) * len;
    return n;
  endfunction

  // columns 0..n-1 all written since reset
  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < LINE_MAX && col_written[n]) n++;
    return n;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_out, field, got, want);
    mismatches++;
  endtask

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        expected_sums.push_back(predict_area(in_pixel));
        pixels_in++;
        if (!calm && in_gap_odds != 0 && $urandom_range(0, in_gap_odds - 1) == 0)
          in_gap = $urandom_range(1, 11);
      end
      if (in_push && in_full) begin
        // keep offering the same pixel
      end else if (in_gap > 0) begin
        in_gap--;
        in_push <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        in_push <= 1'b1;
        in_pixel <= pending_pixels.pop_front();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("unexpected transfer, area_sum", out_area_sum, 0);
        end else begin
          want = expected_sums.pop_front();
          if (out_area_sum !== want.area_sum)
            report_mismatch("area_sum", out_area_sum, want.area_sum);
          if (out_row_end !== want.row_end)
            report_mismatch("row_end", out_row_end, want.row_end);
          if (out_plane_end !== want.plane_end)
            report_mismatch("plane_end", out_plane_end, want.plane_end);
        end
        results_out++;
        if (out_row_end) rows_out++;
        if (out_plane_end) planes_out++;
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (!calm && out_stall_odds != 0 && $urandom_range(0, out_stall_odds - 1) == 0)
          out_stall = $urandom_range(1, 11);
      end
    end
  end

  // watchdog: too long without any transfer
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("integral_image_builder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_push || expected_sums.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ROW_LENGTH: row_length_reg = val;
      REG_ROW_COUNT:  row_count_reg = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random_pixels(int n);
    logic [7:0] p;
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: p = 8'd0;
        1: p = 8'd255;
        default: p = 8'($urandom);
      endcase
      pending_pixels.push_back(p);
      pixels_queued++;
    end
  endtask

  initial begin
    int        phase;
    int        planes;
    int        plane_px;
    int        limit;
    cfg_data_t len_val;
    cfg_data_t rows_val;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry, then shorten the row and the plane partway through
    pending_pixels = {8'd255, 8'd0, 8'd255, 8'd255, 8'd128};
    pixels_queued += 5;
    wait_idle();
    write_reg(REG_ROW_LENGTH, 11'd3);
    write_reg(REG_ROW_COUNT, 11'd2);
    queue_random_pixels(pixels_to_plane_end());
    wait_idle();

    // zero lengths act as one: every pixel closes a row and a plane
    write_reg(REG_ROW_LENGTH, 11'd0);
    write_reg(REG_ROW_COUNT, 11'd0);
    pending_pixels = {8'd255, 8'd0};
    pixels_queued += 2;
    wait_idle();

    // oversized lengths clamp to the maximum; cut the row short mid-plane
    write_reg(REG_ROW_LENGTH, 11'd2047);
    write_reg(REG_ROW_COUNT, 11'd2047);
    queue_random_pixels(3);
    wait_idle();
    write_reg(REG_ROW_LENGTH, 11'd0);
    write_reg(REG_ROW_COUNT, 11'd2);
    queue_random_pixels(pixels_to_plane_end());
    wait_idle();

    phase = 0;
    while (pixels_queued < PIXEL_TOTAL) begin
      phase++;
      if (pixels_queued > PIXEL_TOTAL - 200) calm = 1'b1;
      case ($urandom_range(0, 3))
        0: begin in_gap_odds = 0; out_stall_odds = 0; end
        1: begin in_gap_odds = 3; out_stall_odds = 3; end
        default: begin in_gap_odds = $urandom_range(2, 12); out_stall_odds = $urandom_range(2, 12); end
      endcase
      case ($urandom_range(0, 9))
        0: len_val = 11'd0;
        1: len_val = 11'd1;
        default: len_val = 11'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 9))
        0: rows_val = 11'd0;
        1: rows_val = 11'd1;
        default: rows_val = 11'($urandom_range(2, 6));
      endcase
      planes = $urandom_range(1, 3);
      if (phase == 3) begin
        // one full-width row with a long output hold: the block backs up
        len_val = 11'd1024;
        rows_val = 11'd1;
        planes = 1;
        in_gap_odds = 0;
        calm = 1'b1;
      end
      wait_idle();
      write_reg(REG_ROW_LENGTH, len_val);
      write_reg(REG_ROW_COUNT, rows_val);
      plane_px = eff_len(len_val, LINE_MAX) * eff_len(rows_val, ROWS_MAX);
      if (phase == 3) hold_req = 1'b1;
      repeat (planes) begin
        if (phase != 3 && $urandom_range(0, 3) == 0) begin
          // stop partway, change geometry, then finish the plane
          queue_random_pixels($urandom_range(1, plane_px));
          wait_idle();
          limit = (row_pos == 0) ? 12 : ((written_prefix() < 12) ? written_prefix() : 12);
          write_reg(REG_ROW_LENGTH, 11'($urandom_range(0, limit)));
          write_reg(REG_ROW_COUNT, 11'($urandom_range(0, 6)));
          queue_random_pixels(pixels_to_plane_end());
          wait_idle();
          write_reg(REG_ROW_LENGTH, len_val);
          write_reg(REG_ROW_COUNT, rows_val);
        end else begin
          queue_random_pixels(plane_px);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d pixels, %0d rows and %0d planes over %0d register writes",
             pixels_in, rows_out, planes_out, reg_writes);
    $display("geometry from 1x1 up to full width, mid-plane changes, output held %0d cycles",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("integral_image_builder regression: pass");
    end else begin
      $display("integral_image_builder regression: fail");
    end
    $finish;
  end

endmodule
